// ----- rtl/stz_pkg.sv -----
// Shared types and constants for the source tokenizer.
`timescale 1ns / 1ps

package stz_pkg;

  localparam int OFFSET_W = 32;
  localparam int LENGTH_W = 16;
  localparam int LINE_W   = 32;

  localparam logic [LENGTH_W-1:0] LENGTH_MAX = {LENGTH_W{1'b1}};
  localparam logic [LINE_W-1:0]   LINE_MAX   = {LINE_W{1'b1}};

  typedef enum logic [4:0] {
    KIND_NUMBER  = 5'd0,
    KIND_IDENT   = 5'd1,
    KIND_FN      = 5'd2,
    KIND_LET     = 5'd3,
    KIND_IF      = 5'd4,
    KIND_ELSE    = 5'd5,
    KIND_WHILE   = 5'd6,
    KIND_RETURN  = 5'd7,
    KIND_PRINT   = 5'd8,
    KIND_EQ      = 5'd9,
    KIND_NE      = 5'd10,
    KIND_LE      = 5'd11,
    KIND_GE      = 5'd12,
    KIND_PLUS    = 5'd13,
    KIND_MINUS   = 5'd14,
    KIND_STAR    = 5'd15,
    KIND_SLASH   = 5'd16,
    KIND_LT      = 5'd17,
    KIND_GT      = 5'd18,
    KIND_ASSIGN  = 5'd19,
    KIND_LPAREN  = 5'd20,
    KIND_RPAREN  = 5'd21,
    KIND_LBRACE  = 5'd22,
    KIND_RBRACE  = 5'd23,
    KIND_COMMA   = 5'd24,
    KIND_SEMI    = 5'd25,
    KIND_UNKNOWN = 5'd26,
    KIND_EOF     = 5'd27
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [OFFSET_W-1:0] start_offset;
    logic [LENGTH_W-1:0] token_length;
    logic [LINE_W-1:0]   line_number;
    logic                last_of_run;
  } token_t;

  // Up to two tokens per input byte; second is only valid when first is.
  typedef struct packed {
    logic   first_valid;
    logic   second_valid;
    token_t first;
    token_t second;
  } token_pair_t;

endpackage

// ----- rtl/source_tokenizer_core.sv -----
// Top level of the streaming source tokenizer.
//
//   Channel   Direction  Data                          Side band
//   s_*       in         tdata: char_byte[7:0]         tuser: mode
//   m_*       out        tdata: start_offset[31:0],    tuser: token_kind, tlast: last_of_run
//                               token_length[47:32],
//                               line_number[79:48]
//
// Each source byte is classified and scanned in the cycle it is transferred,
// and its zero, one or two tokens land in a four-entry queue the next cycle.
// A byte is taken every cycle while the queue has room for two tokens; the output side
// drains one token per cycle unless stalled, so bytes that yield two tokens set the pace.
// Synchronous reset empties the queue and returns the scanner to line one, offset zero.
// A stall on the output side holds the current token until it is transferred.
`timescale 1ns / 1ps

module source_tokenizer_core #(
  parameter int KEYWORD_MAX_LEN = 6,
  parameter int POSITION_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_byte
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // start_offset, token_length, line_number
  output logic [4:0]  m_tuser,   // token_kind
  output logic        m_tlast
);
  import stz_pkg::*;

  token_pair_t pair;
  token_t      head_token;
  logic        accept;

  assign accept = s_tvalid && s_tready;

  stz_lexer #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
    .POSITION_BITS  (POSITION_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .mode     (s_tuser),
    .char_byte(s_tdata),
    .results  (pair)
  );

  stz_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(pair),
    .room     (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (head_token)
  );

  assign m_tdata = {head_token.line_number, head_token.token_length, head_token.start_offset};
  assign m_tuser = head_token.kind;
  assign m_tlast = head_token.last_of_run;

endmodule

// ----- rtl/stz_lexer.sv -----
// Scanner state and per-byte classification for the source tokenizer.
`timescale 1ns / 1ps

module stz_lexer #(
  parameter int KEYWORD_MAX_LEN = 6,
  parameter int POSITION_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                mode,
  input  logic [7:0]          char_byte,
  output stz_pkg::token_pair_t results
);
  import stz_pkg::*;

  localparam int IDX_W = (KEYWORD_MAX_LEN > 1) ? $clog2(KEYWORD_MAX_LEN) : 1;

  localparam logic [47:0] KW_FN     = 48'h000000006E66;
  localparam logic [47:0] KW_LET    = 48'h00000074656C;
  localparam logic [47:0] KW_IF     = 48'h000000006669;
  localparam logic [47:0] KW_ELSE   = 48'h000065736C65;
  localparam logic [47:0] KW_WHILE  = 48'h00656C696877;
  localparam logic [47:0] KW_RETURN = 48'h6E7275746572;
  localparam logic [47:0] KW_PRINT  = 48'h00746E697270;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [4:0] {
    SCAN_IDLE    = 5'b00001,
    SCAN_NUMBER  = 5'b00010,
    SCAN_WORD    = 5'b00100,
    SCAN_HELD    = 5'b01000,
    SCAN_COMMENT = 5'b10000
  } scan_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic kind_t punct_kind(logic [7:0] c);
    kind_t k;
    case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h3C:   k = KIND_LT;
      8'h3E:   k = KIND_GT;
      8'h3D:   k = KIND_ASSIGN;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMI;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // Only the first len bytes of the prefix are compared; later ones may be stale.
  function automatic logic word_is(logic [47:0] p, logic [15:0] cnt,
                                   logic [47:0] text, logic [2:0] len);
    logic hit;
    hit = (cnt == {13'b0, len});
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < len) begin
        hit = hit && (p[8*i +: 8] == text[8*i +: 8]);
      end
    end
    return hit;
  endfunction

  scan_t                    scan_mode, scan_mode_next;
  logic [7:0]               held_operator, held_operator_next;
  logic [POSITION_BITS-1:0] token_start, token_start_next;
  logic [LENGTH_W-1:0]      token_count, token_count_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [LINE_W-1:0]        current_line, current_line_next;
  logic [7:0]               word_prefix [KEYWORD_MAX_LEN];

  logic             prefix_we;
  logic [IDX_W-1:0] prefix_idx;
  logic [47:0]      prefix_low;
  logic [OFFSET_W-1:0] pos_offset, start_offset_held;
  kind_t            word_kind, held_kind;
  logic             do_flush, do_start, flush_valid;
  token_t           tok_a, tok_b;
  logic             a_valid, b_valid;
  logic [LENGTH_W-1:0] count_grown;
  logic [LINE_W-1:0]   line_bumped;

  generate
    if (POSITION_BITS >= OFFSET_W) begin : g_pos_trunc
      assign pos_offset        = byte_position[OFFSET_W-1:0];
      assign start_offset_held = token_start[OFFSET_W-1:0];
    end else begin : g_pos_ext
      assign pos_offset        = {{(OFFSET_W-POSITION_BITS){1'b0}}, byte_position};
      assign start_offset_held = {{(OFFSET_W-POSITION_BITS){1'b0}}, token_start};
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      prefix_low[8*i +: 8] = word_prefix[i];
    end
  end

  always_comb begin
    if (token_count > LENGTH_W'(KEYWORD_MAX_LEN)) begin
      word_kind = KIND_IDENT;
    end else if (word_is(prefix_low, token_count, KW_FN, 3'd2)) begin
      word_kind = KIND_FN;
    end else if (word_is(prefix_low, token_count, KW_LET, 3'd3)) begin
      word_kind = KIND_LET;
    end else if (word_is(prefix_low, token_count, KW_IF, 3'd2)) begin
      word_kind = KIND_IF;
    end else if (word_is(prefix_low, token_count, KW_ELSE, 3'd4)) begin
      word_kind = KIND_ELSE;
    end else if (word_is(prefix_low, token_count, KW_WHILE, 3'd5)) begin
      word_kind = KIND_WHILE;
    end else if (word_is(prefix_low, token_count, KW_RETURN, 3'd6)) begin
      word_kind = KIND_RETURN;
    end else if (word_is(prefix_low, token_count, KW_PRINT, 3'd5)) begin
      word_kind = KIND_PRINT;
    end else begin
      word_kind = KIND_IDENT;
    end
  end

  // A lone bang has no single-character meaning.
  assign held_kind   = (held_operator == CH_BANG) ? KIND_UNKNOWN : punct_kind(held_operator);
  assign count_grown = (token_count != LENGTH_MAX) ? token_count + LENGTH_W'(1) : token_count;
  assign line_bumped = (current_line != LINE_MAX) ? current_line + LINE_W'(1) : current_line;
  assign flush_valid = (scan_mode == SCAN_NUMBER) || (scan_mode == SCAN_WORD) ||
                       (scan_mode == SCAN_HELD);

  always_comb begin
    scan_mode_next     = scan_mode;
    held_operator_next = held_operator;
    token_start_next   = token_start;
    token_count_next   = token_count;
    byte_position_next = byte_position + POSITION_BITS'(1);
    current_line_next  = current_line;
    prefix_we          = 1'b0;
    prefix_idx         = token_count[IDX_W-1:0];
    do_flush           = 1'b0;
    do_start           = 1'b0;
    a_valid            = 1'b0;
    b_valid            = 1'b0;

    tok_a.kind         = KIND_NUMBER;
    tok_a.start_offset = start_offset_held;
    tok_a.token_length = token_count;
    tok_a.line_number  = current_line;
    tok_a.last_of_run  = 1'b0;

    tok_b.kind         = punct_kind(char_byte);
    tok_b.start_offset = pos_offset;
    tok_b.token_length = LENGTH_W'(1);
    tok_b.line_number  = current_line;
    tok_b.last_of_run  = 1'b1;

    if (mode) begin
      do_flush = flush_valid;
    end else begin
      case (scan_mode)
        SCAN_NUMBER: begin
          if (is_digit(char_byte) || (char_byte == CH_DOT)) begin
            token_count_next = count_grown;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        SCAN_WORD: begin
          if (is_alpha(char_byte) || is_digit(char_byte) || (char_byte == CH_UNDER)) begin
            prefix_we        = token_count < LENGTH_W'(KEYWORD_MAX_LEN);
            token_count_next = count_grown;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        SCAN_HELD: begin
          if ((char_byte == CH_EQ) && (held_operator != CH_SLASH)) begin
            a_valid            = 1'b1;
            tok_a.token_length = LENGTH_W'(2);
            if (held_operator == CH_EQ) begin
              tok_a.kind = KIND_EQ;
            end else if (held_operator == CH_BANG) begin
              tok_a.kind = KIND_NE;
            end else if (held_operator == CH_LT) begin
              tok_a.kind = KIND_LE;
            end else begin
              tok_a.kind = KIND_GE;
            end
            scan_mode_next = SCAN_IDLE;
          end else if ((char_byte == CH_SLASH) && (held_operator == CH_SLASH)) begin
            scan_mode_next = SCAN_COMMENT;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        SCAN_COMMENT: begin
          if (char_byte == CH_NL) begin
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
    end

    if (do_flush) begin
      a_valid = 1'b1;
      if (scan_mode == SCAN_WORD) begin
        tok_a.kind = word_kind;
      end else if (scan_mode == SCAN_HELD) begin
        tok_a.kind         = held_kind;
        tok_a.token_length = LENGTH_W'(1);
      end else begin
        tok_a.kind = KIND_NUMBER;
      end
    end

    if (do_start) begin
      token_start_next = byte_position;
      token_count_next = LENGTH_W'(1);
      scan_mode_next   = SCAN_IDLE;
      if (char_byte == CH_NL) begin
        current_line_next = line_bumped;
      end else if (is_space(char_byte)) begin
        scan_mode_next = SCAN_IDLE;
      end else if (is_digit(char_byte)) begin
        scan_mode_next = SCAN_NUMBER;
      end else if (is_alpha(char_byte) || (char_byte == CH_UNDER)) begin
        prefix_we      = 1'b1;
        prefix_idx     = '0;
        scan_mode_next = SCAN_WORD;
      end else if ((char_byte == CH_EQ) || (char_byte == CH_BANG) || (char_byte == CH_LT) ||
                   (char_byte == CH_GT) || (char_byte == CH_SLASH)) begin
        held_operator_next = char_byte;
        scan_mode_next     = SCAN_HELD;
      end else begin
        b_valid = 1'b1;
      end
    end

    // The end of the source emits end-of-file and returns everything to reset.
    if (mode) begin
      b_valid            = 1'b1;
      tok_b.kind         = KIND_EOF;
      tok_b.token_length = '0;
      scan_mode_next     = SCAN_IDLE;
      held_operator_next = '0;
      token_start_next   = '0;
      token_count_next   = '0;
      byte_position_next = '0;
      current_line_next  = LINE_W'(1);
    end

    tok_a.last_of_run = !b_valid;
  end

  always_comb begin
    results.first_valid  = a_valid || b_valid;
    results.second_valid = a_valid && b_valid;
    results.first        = a_valid ? tok_a : tok_b;
    results.second       = tok_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= SCAN_IDLE;
      held_operator <= '0;
      token_start   <= '0;
      token_count   <= '0;
      byte_position <= '0;
      current_line  <= LINE_W'(1);
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      held_operator <= held_operator_next;
      token_start   <= token_start_next;
      token_count   <= token_count_next;
      byte_position <= byte_position_next;
      current_line  <= current_line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !mode && prefix_we) begin
      word_prefix[prefix_idx] <= char_byte;
    end
  end

endmodule

// ----- rtl/stz_queue.sv -----
// Four-entry result queue: takes up to two tokens per cycle, gives one when ready.
`timescale 1ns / 1ps

module stz_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  stz_pkg::token_pair_t push_data,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stz_pkg::token_t      out_data
);
  import stz_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t           entries [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] fill, fill_next;
  logic [1:0]       push_count;
  logic             pop;

  assign push_count = push ? ({1'b0, push_data.first_valid} +
                              {1'b0, push_data.second_valid}) : 2'd0;
  assign pop        = out_valid && out_ready;
  assign out_valid  = (fill != '0);
  assign out_data   = entries[head];
  // Room for a worst-case pair without relying on the entry that may leave this cycle.
  assign room       = (fill <= CNT_W'(DEPTH - 2));
  assign fill_next  = fill + CNT_W'(push_count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head + PTR_W'(pop);
      tail <= tail + PTR_W'(push_count);
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_data.first_valid) begin
      entries[tail] <= push_data.first;
    end
    if (push && push_data.second_valid) begin
      entries[tail + PTR_W'(1)] <= push_data.second;
    end
  end

endmodule

// ----- rtl/stz_checker.sv -----
// Port-level checks for the source tokenizer, bound to the top level.
`timescale 1ns / 1ps

module stz_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [4:0]  m_tuser,
  input logic        m_tlast
);
  import stz_pkg::*;

  // A stalled token stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output token dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("output token changed while stalled");

  // End of file is zero length and always closes its run.
  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_EOF) |-> (m_tdata[47:32] == 16'd0) && m_tlast)
    else $error("end-of-file token malformed");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[79:48] != 32'd0))
    else $error("token reported on line zero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("token offered right after reset");

endmodule

bind source_tokenizer_core stz_checker u_stz_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// ----- tb/tb_source_tokenizer_core.sv -----
// Self-checking testbench for the streaming source tokenizer core.
`timescale 1ns / 1ps

module tb_source_tokenizer_core;
  import stz_pkg::*;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_END  = 1'b1;
  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam int KW_MAX = 6;

  localparam int SEND_IDLE_A = 34;
  localparam int RECV_IDLE_A = 58;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_WORD,
    SCAN_HELD,
    SCAN_COMMENT
  } scan_state_t;

  typedef struct packed {
    logic       hold_off;
    logic [1:0] phase;
    logic       mode;
    logic [7:0] char_byte;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // char_byte
  logic        s_tuser = 1'b0;   // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;          // start_offset, token_length, line_number
  logic [4:0]  m_tuser;          // token_kind
  logic        m_tlast;

  source_tokenizer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  src_item_t  pending_items[$];
  token_t     tokens_due[$];
  token_t     step_tokens[$];
  logic       mark_hold = 1'b0;
  logic [1:0] send_phase = 2'd0;
  int         hold_off_requests = 0;
  int         items_taken = 0;
  int         ends_taken = 0;
  int         tokens_checked = 0;
  int         error_count = 0;

  // Scanner state mirrored by the predictor.
  scan_state_t         scan_state = SCAN_IDLE;
  logic [7:0]          held_char = 8'd0;
  logic [OFFSET_W-1:0] pend_start = '0;
  logic [LENGTH_W-1:0] pend_len = '0;
  logic [7:0]          word_head [KW_MAX];
  logic [OFFSET_W-1:0] next_offset = '0;
  logic [LINE_W-1:0]   line_count = 1;

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    case (c)
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      "/":     return KIND_SLASH;
      "<":     return KIND_LT;
      ">":     return KIND_GT;
      "=":     return KIND_ASSIGN;
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      ",":     return KIND_COMMA;
      ";":     return KIND_SEMI;
      default: return KIND_UNKNOWN;
    endcase
  endfunction

  // Only the stored head bytes below the word length are looked at.
  function automatic kind_t word_kind_of();
    case (pend_len)
      16'd2: begin
        if ({word_head[0], word_head[1]} == "fn") return KIND_FN;
        if ({word_head[0], word_head[1]} == "if") return KIND_IF;
      end
      16'd3: if ({word_head[0], word_head[1], word_head[2]} == "let") return KIND_LET;
      16'd4: begin
        if ({word_head[0], word_head[1], word_head[2], word_head[3]} == "else")
          return KIND_ELSE;
      end
      16'd5: begin
        if ({word_head[0], word_head[1], word_head[2], word_head[3], word_head[4]} == "while")
          return KIND_WHILE;
        if ({word_head[0], word_head[1], word_head[2], word_head[3], word_head[4]} == "print")
          return KIND_PRINT;
      end
      16'd6: begin
        if ({word_head[0], word_head[1], word_head[2], word_head[3], word_head[4],
             word_head[5]} == "return")
          return KIND_RETURN;
      end
      default: ;
    endcase
    return KIND_IDENT;
  endfunction

  task automatic emit_token(input kind_t kind, input logic [OFFSET_W-1:0] start,
                            input logic [LENGTH_W-1:0] len);
    token_t tok;
    tok.kind = kind;
    tok.start_offset = start;
    tok.token_length = len;
    tok.line_number = line_count;
    tok.last_of_run = 1'b0;
    step_tokens.insert(step_tokens.size(), tok);
  endtask

  task automatic flush_pending();
    case (scan_state)
      SCAN_NUMBER: emit_token(KIND_NUMBER, pend_start, pend_len);
      SCAN_WORD:   emit_token(word_kind_of(), pend_start, pend_len);
      SCAN_HELD:   emit_token(held_char == "!" ? KIND_UNKNOWN : punct_kind(held_char),
                              pend_start, 16'd1);
      default: ;
    endcase
    scan_state = SCAN_IDLE;
  endtask

  task automatic begin_token(input logic [7:0] c, input logic [OFFSET_W-1:0] pos);
    pend_start = pos;
    pend_len = 16'd1;
    if (c == NEWLINE) begin
      if (line_count != LINE_MAX) line_count++;
    end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      // Other whitespace is skipped.
    end else if (is_digit(c)) begin
      scan_state = SCAN_NUMBER;
    end else if (is_alpha(c) || c == "_") begin
      word_head[0] = c;
      scan_state = SCAN_WORD;
    end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "/") begin
      held_char = c;
      scan_state = SCAN_HELD;
    end else begin
      emit_token(punct_kind(c), pos, 16'd1);
    end
  endtask

  task automatic predict_tokens(input logic mode, input logic [7:0] c);
    step_tokens.delete();
    if (mode == MODE_END) begin
      flush_pending();
      emit_token(KIND_EOF, next_offset, '0);
      scan_state = SCAN_IDLE;
      held_char = 8'd0;
      pend_start = '0;
      pend_len = '0;
      next_offset = '0;
      line_count = 1;
    end else begin
      case (scan_state)
        SCAN_NUMBER: begin
          if (is_digit(c) || c == ".") begin
            if (pend_len != LENGTH_MAX) pend_len++;
          end else begin
            flush_pending();
            begin_token(c, next_offset);
          end
        end
        SCAN_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            if (pend_len < KW_MAX) word_head[pend_len] = c;
            if (pend_len != LENGTH_MAX) pend_len++;
          end else begin
            flush_pending();
            begin_token(c, next_offset);
          end
        end
        SCAN_HELD: begin
          if (c == "=" && held_char != "/") begin
            emit_token(held_char == "=" ? KIND_EQ : held_char == "!" ? KIND_NE :
                       held_char == "<" ? KIND_LE : KIND_GE, pend_start, 16'd2);
            scan_state = SCAN_IDLE;
          end else if (c == "/" && held_char == "/") begin
            scan_state = SCAN_COMMENT;
          end else begin
            flush_pending();
            begin_token(c, next_offset);
          end
        end
        SCAN_COMMENT: begin
          if (c == NEWLINE) begin
            scan_state = SCAN_IDLE;
            begin_token(c, next_offset);
          end
        end
        default: begin
          scan_state = SCAN_IDLE;
          begin_token(c, next_offset);
        end
      endcase
      next_offset++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
    foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
  endtask

  task automatic push_byte(input logic [7:0] c, input logic [1:0] ph);
    src_item_t it;
    it.hold_off = mark_hold;
    it.phase = ph;
    it.mode = MODE_BYTE;
    it.char_byte = c;
    mark_hold = 1'b0;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_text(input string s, input logic [1:0] ph);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], ph);
  endtask

  task automatic push_end(input logic [1:0] ph);
    src_item_t it;
    it.hold_off = 1'b0;
    it.phase = ph;
    it.mode = MODE_END;
    it.char_byte = 8'($urandom_range(0, 255));
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [7:0] rand_word_char(input logic lead);
    int r;
    r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r == 52) return "_";
    return 8'(8'h30 + r - 53);
  endfunction

  // One random fragment of source text; mostly well-formed lexemes.
  task automatic add_fragment(input logic [1:0] ph);
    int pick;
    int n;
    string s;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 6))
        0: s = "fn";
        1: s = "let";
        2: s = "if";
        3: s = "else";
        4: s = "while";
        5: s = "return";
        default: s = "print";
      endcase
      n = $urandom_range(0, 9);
      // Truncated or extended keywords must come out as identifiers.
      if (n == 0) s = s.substr(0, s.len() - 2);
      push_text(s, ph);
      if (n == 1) push_byte(rand_word_char(1'b0), ph);
    end else if (pick < 30) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      push_byte(rand_word_char(1'b1), ph);
      repeat (n - 1) push_byte(rand_word_char(1'b0), ph);
    end else if (pick < 42) begin
      push_byte(8'(8'h30 + $urandom_range(0, 9)), ph);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 4) == 0) push_byte(".", ph);
        else push_byte(8'(8'h30 + $urandom_range(0, 9)), ph);
      end
    end else if (pick < 58) begin
      case ($urandom_range(0, 11))
        0: s = "==";
        1: s = "!=";
        2: s = "<=";
        3: s = ">=";
        4: s = "===";
        5: s = "!";
        6: s = "<";
        7: s = ">";
        8: s = "=";
        9: s = "/";
        default: begin
          s = "+-*/<>=(){},;";
          n = $urandom_range(0, 12);
          s = s.substr(n, n);
        end
      endcase
      push_text(s, ph);
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 3)) begin
        c = ($urandom_range(0, 5) == 0) ? 8'd32 : 8'(8 + $urandom_range(1, 5));
        push_byte(c, ph);
      end
    end else if (pick < 82) begin
      push_text("//", ph);
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(0, 255));
        if (c == NEWLINE) c = "#";
        push_byte(c, ph);
      end
      if ($urandom_range(0, 3) != 0) push_byte(NEWLINE, ph);
    end else if (pick < 97) begin
      push_byte(8'($urandom_range(0, 255)), ph);
    end else begin
      push_end(ph);
    end
    if ($urandom_range(0, 1) == 1) push_byte(" ", ph);
  endtask

  // Source side: presents queued items and predicts on every transfer.
  always @(posedge clk) begin : byte_driver
    src_item_t it;
    int idle_pct;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_tokens(s_tuser, s_tdata);
        items_taken++;
        if (s_tuser == MODE_END) ends_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0) begin
          idle_pct = (pending_items[0].phase == 2'd0) ? SEND_IDLE_A :
                     (pending_items[0].phase == 2'd1) ? RECV_IDLE_A : 0;
        end else begin
          idle_pct = 100;
        end
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it.char_byte;
          s_tuser <= it.mode;
          send_phase <= it.phase;
          if (it.hold_off) hold_off_requests <= hold_off_requests + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Token side: random back-pressure plus one long hold-off on request.
  always @(posedge clk) begin : token_monitor
    token_t seen;
    token_t want;
    logic ready_next;
    int idle_pct;
    int stall_left;
    int hold_off_served;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      hold_off_served = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen.kind = kind_t'(m_tuser);
        seen.start_offset = m_tdata[31:0];
        seen.token_length = m_tdata[47:32];
        seen.line_number = m_tdata[79:48];
        seen.last_of_run = m_tlast;
        if (tokens_due.size() == 0) begin
          note_failure($sformatf("Unexpected token: kind %0d off %0d len %0d line %0d last %0b",
                                 seen.kind, seen.start_offset, seen.token_length,
                                 seen.line_number, seen.last_of_run));
        end else begin
          want = tokens_due.pop_front();
          tokens_checked++;
          if (seen !== want) begin
            note_failure($sformatf(
              "Token %0d mismatch: expected kind %0d off %0d len %0d line %0d last %0b, got kind %0d off %0d len %0d line %0d last %0b",
              tokens_checked, want.kind, want.start_offset, want.token_length,
              want.line_number, want.last_of_run, seen.kind, seen.start_offset,
              seen.token_length, seen.line_number, seen.last_of_run));
          end
        end
      end
      if (hold_off_requests != hold_off_served) begin
        hold_off_served = hold_off_requests;
        stall_left = HOLD_OFF_CYCLES;
      end
      idle_pct = (send_phase == 2'd0) ? RECV_IDLE_A : (send_phase == 2'd1) ? SEND_IDLE_A : 0;
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = ($urandom_range(0, 99) >= idle_pct);
      end
      m_tready <= ready_next;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int goal;
    // Dotted number, word, lone bang, repeated equals, both compares, lone slash,
    // a comment, a dot that starts nothing, controls and high bytes, held flush at end.
    push_text("9.1_a!b===<=>=/x//q\n.", 2'd0);
    push_byte(8'h00, 2'd0);
    push_byte(8'h7F, 2'd0);
    push_byte(8'h80, 2'd0);
    push_byte(8'hFF, 2'd0);
    push_text("<", 2'd0);
    push_end(2'd0);

    goal = pending_items.size() + 430;
    while (pending_items.size() < goal) add_fragment(2'd0);
    goal += 430;
    while (pending_items.size() < goal) add_fragment(2'd1);
    goal += 200;
    while (pending_items.size() < goal) add_fragment(2'd2);
    mark_hold = 1'b1;
    goal += 230;
    while (pending_items.size() < goal) add_fragment(2'd2);
    push_end(2'd2);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || s_tvalid) @(negedge clk);
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d source items with %0d end markers, checked %0d tokens over three",
             items_taken, ends_taken, tokens_checked);
    $display("back-pressure profiles and a long output stall; %0d failures.",
             error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/stz_pkg.sv
rtl/stz_lexer.sv
rtl/stz_queue.sv
rtl/source_tokenizer_core.sv
rtl/stz_checker.sv
tb/tb_source_tokenizer_core.sv
